>>> rtl/core/mdms_pkg.sv
`default_nettype none

package mdms_pkg;

    // Mode codes as seen on requested_mode and mode
    localparam logic [2:0] MODE_BOOT = 3'd0;
    localparam logic [2:0] MODE_IDLE = 3'd1;
    localparam logic [2:0] MODE_RUN  = 3'd2;
    localparam logic [2:0] MODE_CAL  = 3'd3;
    localparam logic [2:0] MODE_ANTI = 3'd4;

    // Actions carried in s_tuser
    localparam logic [2:0] ACT_REQUEST   = 3'd0;
    localparam logic [2:0] ACT_CONTROL   = 3'd1;
    localparam logic [2:0] ACT_SAFETY    = 3'd2;
    localparam logic [2:0] ACT_SUPERVISE = 3'd3;
    localparam logic [2:0] ACT_CLEAR     = 3'd4;
    localparam logic [2:0] ACT_LED       = 3'd5;

    // Request status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_FAULTS   = 2'd2;
    localparam logic [1:0] STAT_NOT_CAL  = 2'd3;

    // Fault flag bits
    localparam int FLT_OVERCURRENT = 0;
    localparam int FLT_OVERVOLTAGE = 1;
    localparam int FLT_UNDERVOLT   = 2;
    localparam int FLT_DRIVER_HOT  = 3;
    localparam int FLT_BOARD_HOT   = 4;

    // Configuration register indexes
    localparam logic [2:0] REG_CURRENT_LIMIT = 3'd0;
    localparam logic [2:0] REG_VOLT_HIGH     = 3'd1;
    localparam logic [2:0] REG_VOLT_LOW      = 3'd2;
    localparam logic [2:0] REG_DRIVER_TEMP   = 3'd3;
    localparam logic [2:0] REG_BOARD_TEMP    = 3'd4;
    localparam logic [2:0] REG_CALIBRATED    = 3'd5;
    localparam logic [2:0] REG_CHARGE_TICKS  = 3'd6;

    // Configuration reset values
    localparam logic [14:0]        RST_CURRENT_LIMIT = 15'd20000;
    localparam logic [15:0]        RST_VOLT_HIGH     = 16'd50000;
    localparam logic [15:0]        RST_VOLT_LOW      = 16'd12000;
    localparam logic signed [11:0] RST_DRIVER_TEMP   = 12'sd1200;
    localparam logic signed [11:0] RST_BOARD_TEMP    = 12'sd1000;
    localparam logic [15:0]        RST_CHARGE_TICKS  = 16'd200;

    // LED blink pattern: pulse window (20 ticks per pulse) and period per mode
    localparam logic [15:0] LED_WIN_IDLE = 16'd20;
    localparam logic [15:0] LED_WIN_RUN  = 16'd40;
    localparam logic [15:0] LED_WIN_CAL  = 16'd60;
    localparam logic [15:0] LED_WIN_ANTI = 16'd80;
    localparam logic [15:0] LED_PER_IDLE = 16'd100;
    localparam logic [15:0] LED_PER_RUN  = 16'd100;
    localparam logic [15:0] LED_PER_CAL  = 16'd150;
    localparam logic [15:0] LED_PER_ANTI = 16'd200;
    localparam logic [15:0] BLINK_WRAP   = 16'hFFFF;

    typedef enum logic [4:0] {
        ST_BOOT = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_CAL  = 5'b01000,
        ST_ANTI = 5'b10000
    } mode_st_t;

    typedef struct packed {
        logic [14:0]        current_limit;
        logic [15:0]        voltage_high_limit;
        logic [15:0]        voltage_low_limit;
        logic signed [11:0] driver_temp_limit;
        logic signed [11:0] board_temp_limit;
        logic               calibrated;
        logic [15:0]        charge_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [2:0]         requested_mode;
        logic signed [15:0] phase_a_current;
        logic signed [15:0] phase_b_current;
        logic [15:0]        bus_voltage;
        logic signed [11:0] driver_temp;
        logic signed [11:0] board_temp;
    } item_t;

    typedef struct packed {
        mode_st_t    cur;
        mode_st_t    pending;
        logic        exit_done;
        logic [15:0] countdown;
        logic        armed;
        logic        running;
        logic [4:0]  faults;
        logic [4:0]  reported;
        logic [15:0] last_bus;
        logic [15:0] blink;
        logic        led;
    } state_t;

    typedef struct packed {
        logic [1:0] request_status;
        logic [2:0] mode;
        logic       armed;
        logic       drive_on;
        logic [4:0] fault_flags;
        logic       report_pulse;
        logic       led_on;
    } result_t;

    function automatic logic [2:0] mode_code(mode_st_t m);
        logic [2:0] c;
        case (m)
            ST_BOOT: c = MODE_BOOT;
            ST_IDLE: c = MODE_IDLE;
            ST_RUN:  c = MODE_RUN;
            ST_CAL:  c = MODE_CAL;
            ST_ANTI: c = MODE_ANTI;
            default: c = MODE_BOOT;
        endcase
        return c;
    endfunction

    function automatic mode_st_t mode_from_code(logic [2:0] c);
        mode_st_t m;
        case (c)
            MODE_IDLE: m = ST_IDLE;
            MODE_RUN:  m = ST_RUN;
            MODE_CAL:  m = ST_CAL;
            MODE_ANTI: m = ST_ANTI;
            default:   m = ST_BOOT;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mdms_cfg_regs.sv
`default_nettype none

module mdms_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output mdms_pkg::cfg_t     cfg
);
    import mdms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CURRENT_LIMIT: cfg_next.current_limit      = cfg_data[14:0];
                REG_VOLT_HIGH:     cfg_next.voltage_high_limit = cfg_data;
                REG_VOLT_LOW:      cfg_next.voltage_low_limit  = cfg_data;
                REG_DRIVER_TEMP:   cfg_next.driver_temp_limit  = $signed(cfg_data[11:0]);
                REG_BOARD_TEMP:    cfg_next.board_temp_limit   = $signed(cfg_data[11:0]);
                REG_CALIBRATED:    cfg_next.calibrated         = cfg_data[0];
                REG_CHARGE_TICKS:  cfg_next.charge_ticks       = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_limit      <= RST_CURRENT_LIMIT;
            cfg_reg.voltage_high_limit <= RST_VOLT_HIGH;
            cfg_reg.voltage_low_limit  <= RST_VOLT_LOW;
            cfg_reg.driver_temp_limit  <= RST_DRIVER_TEMP;
            cfg_reg.board_temp_limit   <= RST_BOARD_TEMP;
            cfg_reg.calibrated         <= 1'b0;
            cfg_reg.charge_ticks       <= RST_CHARGE_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/mdms_step.sv
`default_nettype none

module mdms_step (
    input  mdms_pkg::cfg_t    cfg,
    input  mdms_pkg::state_t  state,
    input  mdms_pkg::item_t   item,
    output mdms_pkg::state_t  sup_next,
    output mdms_pkg::result_t result
);
    import mdms_pkg::*;

    // Request check; status only, no side effects
    function automatic logic [1:0] req_status(state_t s, logic [2:0] req, logic cal);
        logic [1:0] st;
        st = STAT_OK;
        if (s.cur == ST_IDLE)
        begin
            if (req == MODE_IDLE)
                st = STAT_OK;
            else if (req inside {MODE_RUN, MODE_CAL, MODE_ANTI})
            begin
                if (s.faults != 5'd0)
                    st = STAT_FAULTS;
                else if (req != MODE_CAL && !cal)
                    st = STAT_NOT_CAL;
            end
            else
                st = STAT_INVALID;
        end
        else if (req != MODE_IDLE)
            st = STAT_INVALID;
        return st;
    endfunction

    // Request side effects on the state
    function automatic state_t req_apply(state_t s, logic [2:0] req, logic cal,
                                         logic [15:0] ticks);
        state_t r;
        r = s;
        r.exit_done = 1'b0;
        if (s.cur == ST_IDLE)
        begin
            if (req == MODE_IDLE)
            begin
                r.armed     = 1'b0;
                r.countdown = 16'd0;
                r.pending   = ST_IDLE;
            end
            else if (req inside {MODE_RUN, MODE_CAL, MODE_ANTI})
            begin
                if (s.faults == 5'd0 && (req == MODE_CAL || cal))
                begin
                    r.armed     = 1'b1;
                    r.countdown = ticks;
                    r.pending   = mode_from_code(req);
                end
            end
        end
        else if (req == MODE_IDLE)
            r.pending = ST_IDLE;
        return r;
    endfunction

    function automatic logic [17:0] abs18(logic signed [17:0] v);
        logic signed [17:0] n;
        n = -v;
        return v[17] ? n : v;
    endfunction

    state_t             st;
    logic [1:0]         status;
    logic               pulse;
    logic signed [17:0] ia;
    logic signed [17:0] ib;
    logic signed [17:0] ic;
    logic [17:0]        lim18;
    logic               over;
    logic               blink_en;
    logic [15:0]        win;
    logic [15:0]        period;
    logic               hit;
    logic               on;

    assign ia    = {{2{item.phase_a_current[15]}}, item.phase_a_current};
    assign ib    = {{2{item.phase_b_current[15]}}, item.phase_b_current};
    assign ic    = -(ia + ib);
    assign lim18 = {3'b000, cfg.current_limit};
    assign over  = (abs18(ia) > lim18) || (abs18(ib) > lim18) || (abs18(ic) > lim18);

    // Blink pattern per mode
    always_comb
    begin
        blink_en = 1'b1;
        win      = LED_WIN_IDLE;
        period   = LED_PER_IDLE;
        case (state.cur)
            ST_IDLE:
            begin
                win    = LED_WIN_IDLE;
                period = LED_PER_IDLE;
            end
            ST_RUN:
            begin
                win    = LED_WIN_RUN;
                period = LED_PER_RUN;
            end
            ST_CAL:
            begin
                win    = LED_WIN_CAL;
                period = LED_PER_CAL;
            end
            ST_ANTI:
            begin
                win    = LED_WIN_ANTI;
                period = LED_PER_ANTI;
            end
            default: blink_en = 1'b0;
        endcase
    end

    // Pulse edges: multiples of ten up to 70; LED lights on even tens
    always_comb
    begin
        hit = 1'b1;
        on  = 1'b0;
        case (state.blink)
            16'd0, 16'd20, 16'd40, 16'd60: on = 1'b1;
            16'd10, 16'd30, 16'd50, 16'd70: on = 1'b0;
            default: hit = 1'b0;
        endcase
    end

    always_comb
    begin
        st     = state;
        status = STAT_OK;
        pulse  = 1'b0;
        case (item.action)
            ACT_REQUEST:
            begin
                status = req_status(state, item.requested_mode, cfg.calibrated);
                st     = req_apply(state, item.requested_mode, cfg.calibrated,
                                   cfg.charge_ticks);
            end
            ACT_CONTROL:
            begin
                if (st.pending != st.cur)
                begin
                    if (st.cur == ST_IDLE)
                    begin
                        if (st.countdown != 16'd0)
                            st.countdown = st.countdown - 16'd1;
                        else
                            st.exit_done = 1'b1;
                    end
                    else
                    begin
                        if (st.cur == ST_RUN)
                        begin
                            st.armed   = 1'b0;
                            st.running = 1'b0;
                        end
                        st.exit_done = 1'b1;
                    end
                    if (st.exit_done)
                    begin
                        st.cur = st.pending;
                        if (st.cur == ST_RUN)
                            st.running = 1'b1;
                    end
                end
                st.last_bus = item.bus_voltage;
                if ((st.cur == ST_RUN || st.cur == ST_CAL || st.cur == ST_ANTI) && over)
                begin
                    st.armed = 1'b0;
                    st = req_apply(st, MODE_IDLE, cfg.calibrated, cfg.charge_ticks);
                    st.faults[FLT_OVERCURRENT] = 1'b1;
                end
            end
            ACT_SAFETY:
            begin
                if (st.cur != ST_BOOT)
                begin
                    if (st.last_bus > cfg.voltage_high_limit)
                        st.faults[FLT_OVERVOLTAGE] = 1'b1;
                    if (st.last_bus < cfg.voltage_low_limit)
                        st.faults[FLT_UNDERVOLT] = 1'b1;
                    if ($signed(item.driver_temp) > $signed(cfg.driver_temp_limit))
                        st.faults[FLT_DRIVER_HOT] = 1'b1;
                    if ($signed(item.board_temp) > $signed(cfg.board_temp_limit))
                        st.faults[FLT_BOARD_HOT] = 1'b1;
                end
            end
            ACT_SUPERVISE:
            begin
                if (st.reported != st.faults)
                begin
                    if (st.faults != 5'd0)
                    begin
                        st.armed = 1'b0;
                        st = req_apply(st, MODE_IDLE, cfg.calibrated, cfg.charge_ticks);
                    end
                    pulse       = 1'b1;
                    st.reported = st.faults;
                end
            end
            ACT_CLEAR:
            begin
                st.faults   = 5'd0;
                st.reported = 5'd0;
            end
            ACT_LED:
            begin
                if (blink_en)
                begin
                    if (state.blink < win && hit)
                        st.led = on;
                    else if (state.blink > period)
                        st.blink = BLINK_WRAP;
                end
                st.blink = st.blink + 16'd1;
            end
            default: st = state;
        endcase
    end

    assign sup_next = st;

    assign result.request_status = status;
    assign result.mode           = mode_code(st.cur);
    assign result.armed          = st.armed;
    assign result.drive_on       = st.running;
    assign result.fault_flags    = st.faults;
    assign result.report_pulse   = pulse;
    assign result.led_on         = st.led;

endmodule

`default_nettype wire

>>> rtl/core/motor_drive_mode_supervisor_top.sv
// Channel   Dir  Signals                         Content
// -------   ---  ------------------------------  --------------------------------------
// s_*       in   s_tvalid s_tready s_tdata s_tuser  one item: action + sample fields
// m_*       out  m_tvalid m_tready m_tdata        one result per item
// cfg_*     in   cfg_valid cfg_ready cfg_index cfg_data  register writes, always ready
//
// One item per cycle sustained while m_tready is high. Path to the result, in order:
// input register, then mode/fault update logic into the result register and state.
// rst_n (async, active low) returns modes to boot, clears faults, counters, LED,
// and loads the register defaults. A stalled m_tready holds the result register;
// the input register still takes one more item, then s_tready drops.
`default_nettype none

module motor_drive_mode_supervisor_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // [2:0] requested_mode, [18:3] phase_a_current, [34:19] phase_b_current,
    // [50:35] bus_voltage, [62:51] driver_temp, [74:63] board_temp, [79:75] unused
    input  wire logic [79:0] s_tdata,
    // [2:0] action
    input  wire logic [2:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] request_status, [4:2] mode, [5] armed, [6] drive_on,
    // [11:7] fault_flags, [12] report_pulse, [13] led_on, [15:14] zero
    output logic [15:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import mdms_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    state_t  state_reg;
    state_t  sup_next;
    result_t result;
    result_t out_data_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    s_take;
    logic    advance;

    assign cfg_ready = 1'b1;

    mdms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Item moves into the result register when there is room
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_item_reg.action          <= s_tuser;
            in_item_reg.requested_mode  <= s_tdata[2:0];
            in_item_reg.phase_a_current <= $signed(s_tdata[18:3]);
            in_item_reg.phase_b_current <= $signed(s_tdata[34:19]);
            in_item_reg.bus_voltage     <= s_tdata[50:35];
            in_item_reg.driver_temp     <= $signed(s_tdata[62:51]);
            in_item_reg.board_temp      <= $signed(s_tdata[74:63]);
        end
    end

    mdms_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_item_reg),
        .sup_next   (sup_next),
        .result     (result)
    );

    // Supervisor state commits with the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.cur       <= ST_BOOT;
            state_reg.pending   <= ST_BOOT;
            state_reg.exit_done <= 1'b0;
            state_reg.countdown <= 16'd0;
            state_reg.armed     <= 1'b0;
            state_reg.running   <= 1'b0;
            state_reg.faults    <= 5'd0;
            state_reg.reported  <= 5'd0;
            state_reg.last_bus  <= 16'd0;
            state_reg.blink     <= 16'd0;
            state_reg.led       <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= sup_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_data_reg.led_on,
                       out_data_reg.report_pulse,
                       out_data_reg.fault_flags,
                       out_data_reg.drive_on,
                       out_data_reg.armed,
                       out_data_reg.mode,
                       out_data_reg.request_status};

`ifndef SYNTHESIS
    // drive_on tracks run mode exactly
    a_running_is_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.running == (state_reg.cur == ST_RUN))
        else $error("drive_on out of step with run mode");

    // boot mode is never armed
    a_boot_unarmed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.cur == ST_BOOT) |-> !state_reg.armed)
        else $error("power stage armed in boot mode");

    // an item moved out of the input register shows up as a result next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");
`endif

endmodule

`default_nettype wire

>>> verif/tb_motor_drive_mode_supervisor_top.sv
module tb_motor_drive_mode_supervisor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mdms_pkg::*;

    // Action and mode codes outside the package's named set
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam logic [2:0] MODE_BAD5  = 3'd5;
    localparam logic [2:0] MODE_BAD7  = 3'd7;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PLAN_ROWS      = 25;
    localparam int REPORT_LIMIT   = 10;

    // One row of the directed plan. pin = 1 means status and mode are
    // typed in here and override the predicted values.
    typedef struct packed {
        logic [2:0]         act;
        logic [2:0]         req;
        logic signed [15:0] ia;
        logic signed [15:0] ib;
        logic [15:0]        bus;
        logic signed [11:0] dt;
        logic signed [11:0] bt;
        logic               pin;
        logic [1:0]         pin_status;
        logic [2:0]         pin_mode;
    } plan_row_t;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    motor_drive_mode_supervisor_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor copy of the register file and supervisor state,
    // starting from the reset values
    // ------------------------------------------------------------------
    logic [14:0]        lim_current  = RST_CURRENT_LIMIT;
    logic [15:0]        lim_vhigh    = RST_VOLT_HIGH;
    logic [15:0]        lim_vlow     = RST_VOLT_LOW;
    logic signed [11:0] lim_drv_temp = RST_DRIVER_TEMP;
    logic signed [11:0] lim_brd_temp = RST_BOARD_TEMP;
    logic               is_calibrated = 1'b0;
    logic [15:0]        charge_len   = RST_CHARGE_TICKS;

    logic [2:0]  mode_now      = MODE_BOOT;
    logic [2:0]  mode_pending  = MODE_BOOT;
    logic        leave_done    = 1'b0;
    logic [15:0] charge_left   = '0;
    logic        stage_on      = 1'b0;
    logic        switched      = 1'b0;
    logic [4:0]  fault_latch   = '0;
    logic [4:0]  fault_seen    = '0;
    logic [15:0] bus_seen      = '0;
    logic [15:0] blink_ticks   = '0;
    logic        led_lvl       = 1'b0;

    result_t     due_results[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 21;
    int          recv_idle_pct = 65;
    plan_row_t   plan [PLAN_ROWS];

    // Mode request check; sets the pending mode, arming and charge countdown
    function automatic logic [1:0] take_request(logic [2:0] req);
        logic [1:0] st;
        st = STAT_OK;
        if (mode_now == MODE_IDLE)
        begin
            if (req == MODE_IDLE)
            begin
                stage_on = 1'b0;
                charge_left = '0;
                mode_pending = MODE_IDLE;
            end
            else if (req == MODE_RUN || req == MODE_CAL || req == MODE_ANTI)
            begin
                if (fault_latch != 0)
                    st = STAT_FAULTS;
                else if (req != MODE_CAL && !is_calibrated)
                    st = STAT_NOT_CAL;
                else
                begin
                    stage_on = 1'b1;
                    charge_left = charge_len;
                    mode_pending = req;
                end
            end
            else
                st = STAT_INVALID;
        end
        else if (req == MODE_IDLE)
            mode_pending = MODE_IDLE;
        else
            st = STAT_INVALID;
        leave_done = 1'b0;
        return st;
    endfunction

    function automatic bit over_limit(int amps);
        return ((amps < 0) ? -amps : amps) > int'(lim_current);
    endfunction

    function automatic void control_advance(item_t it);
        int ia, ib, ic;
        if (mode_pending != mode_now)
        begin
            if (mode_now == MODE_IDLE)
            begin
                // bootstrap charge countdown before leaving idle
                if (charge_left != 0)
                    charge_left = charge_left - 16'd1;
                else
                    leave_done = 1'b1;
            end
            else
            begin
                if (mode_now == MODE_RUN)
                begin
                    stage_on = 1'b0;
                    switched = 1'b0;
                end
                leave_done = 1'b1;
            end
            if (leave_done)
            begin
                mode_now = mode_pending;
                if (mode_now == MODE_RUN)
                    switched = 1'b1;
            end
        end
        bus_seen = it.bus_voltage;
        ia = it.phase_a_current;
        ib = it.phase_b_current;
        ic = -(ia + ib);
        if (mode_now == MODE_RUN || mode_now == MODE_CAL || mode_now == MODE_ANTI)
        begin
            if (over_limit(ia) || over_limit(ib) || over_limit(ic))
            begin
                stage_on = 1'b0;
                void'(take_request(MODE_IDLE));
                fault_latch[FLT_OVERCURRENT] = 1'b1;
            end
        end
    endfunction

    function automatic void led_advance();
        int window, span, b;
        window = 0;
        span = 0;
        b = blink_ticks;
        case (mode_now)
            MODE_IDLE: begin window = LED_WIN_IDLE; span = LED_PER_IDLE; end
            MODE_RUN:  begin window = LED_WIN_RUN;  span = LED_PER_RUN;  end
            MODE_CAL:  begin window = LED_WIN_CAL;  span = LED_PER_CAL;  end
            MODE_ANTI: begin window = LED_WIN_ANTI; span = LED_PER_ANTI; end
            default:   ;
        endcase
        // boot mode leaves the LED alone but the tick count still runs
        if (window != 0)
        begin
            if (b < window && b % 10 == 0)
                led_lvl = ((b / 10) % 2 == 1) ? 1'b0 : 1'b1;
            else if (b > span)
                b = BLINK_WRAP;
        end
        blink_ticks = 16'(b + 1);
    endfunction

    // Supervisor state update for one accepted item, returns its result
    function automatic result_t supervisor_next(item_t it);
        result_t r;
        r = '0;
        case (it.action)
            ACT_REQUEST: r.request_status = take_request(it.requested_mode);
            ACT_CONTROL: control_advance(it);
            ACT_SAFETY:
                if (mode_now != MODE_BOOT)
                begin
                    if (bus_seen > lim_vhigh)
                        fault_latch[FLT_OVERVOLTAGE] = 1'b1;
                    if (bus_seen < lim_vlow)
                        fault_latch[FLT_UNDERVOLT] = 1'b1;
                    if (it.driver_temp > lim_drv_temp)
                        fault_latch[FLT_DRIVER_HOT] = 1'b1;
                    if (it.board_temp > lim_brd_temp)
                        fault_latch[FLT_BOARD_HOT] = 1'b1;
                end
            ACT_SUPERVISE:
                if (fault_seen != fault_latch)
                begin
                    if (fault_latch != 0)
                    begin
                        stage_on = 1'b0;
                        void'(take_request(MODE_IDLE));
                    end
                    r.report_pulse = 1'b1;
                    fault_seen = fault_latch;
                end
            ACT_CLEAR:
            begin
                fault_latch = '0;
                fault_seen = '0;
            end
            ACT_LED: led_advance();
            default: ;
        endcase
        r.mode = mode_now;
        r.armed = stage_on;
        r.drive_on = switched;
        r.fault_flags = fault_latch;
        r.led_on = led_lvl;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random item source; leans toward legal mode sequences and
    // in-limit samples so the active modes are actually reached
    // ------------------------------------------------------------------
    function automatic item_t draw_item();
        item_t it;
        int r, bound;
        it = '0;
        r = $urandom_range(99);
        if (r < 14)
            it.action = ACT_REQUEST;
        else if (r < 42)
            it.action = ACT_CONTROL;
        else if (r < 50)
            it.action = ACT_SAFETY;
        else if (r < 58)
            it.action = ACT_SUPERVISE;
        else if (r < 63)
            it.action = ACT_CLEAR;
        else if (r < 98)
            it.action = ACT_LED;
        else
            it.action = ($urandom_range(1) == 1) ? ACT_SPARE7 : ACT_SPARE6;

        r = $urandom_range(99);
        if (mode_now == MODE_IDLE && r < 70)
        begin
            case ($urandom_range(2))
                0:       it.requested_mode = MODE_RUN;
                1:       it.requested_mode = MODE_CAL;
                default: it.requested_mode = MODE_ANTI;
            endcase
        end
        else if (r < 85)
            it.requested_mode = MODE_IDLE;
        else
            it.requested_mode = 3'($urandom_range(7));

        // mostly currents that cannot trip, even through the derived phase
        if ($urandom_range(99) < 85)
        begin
            bound = int'(lim_current) / 3;
            it.phase_a_current = 16'(int'($urandom_range(2 * bound)) - bound);
            it.phase_b_current = 16'(int'($urandom_range(2 * bound)) - bound);
        end
        else
        begin
            it.phase_a_current = 16'($urandom);
            it.phase_b_current = 16'($urandom);
        end

        if ($urandom_range(99) < 70 && lim_vlow <= lim_vhigh)
            it.bus_voltage = 16'($urandom_range(lim_vhigh, lim_vlow));
        else
            it.bus_voltage = 16'($urandom_range(65535));

        if ($urandom_range(99) < 85)
        begin
            it.driver_temp = 12'(int'($urandom_range(int'(lim_drv_temp) + 1000)) - 1000);
            it.board_temp = 12'(int'($urandom_range(int'(lim_brd_temp) + 1000)) - 1000);
        end
        else
        begin
            it.driver_temp = 12'(int'($urandom_range(3000)) - 1000);
            it.board_temp = 12'(int'($urandom_range(3000)) - 1000);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transaction per call, random idle before it.
    // The expectation is formed at the accepting edge.
    // ------------------------------------------------------------------
    task automatic push_item(input item_t it, input logic pin,
                             input logic [1:0] pin_status, input logic [2:0] pin_mode);
        result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {5'b0, it.board_temp, it.driver_temp, it.bus_voltage,
                     it.phase_b_current, it.phase_a_current, it.requested_mode};
        do
            @(posedge clk);
        while (!s_tready);
        want = supervisor_next(it);
        if (pin)
        begin
            want.request_status = pin_status;
            want.mode = pin_mode;
        end
        due_results.push_back(want);
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic settle_outputs();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_CURRENT_LIMIT: lim_current = val[14:0];
            REG_VOLT_HIGH:     lim_vhigh = val;
            REG_VOLT_LOW:      lim_vlow = val;
            REG_DRIVER_TEMP:   lim_drv_temp = val[11:0];
            REG_BOARD_TEMP:    lim_brd_temp = val[11:0];
            REG_CALIBRATED:    is_calibrated = val[0];
            REG_CHARGE_TICKS:  charge_len = val;
            default:           ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_limits(input int cur, input int vhi, input int vlo, input int dtl,
                               input int btl, input int cal, input int chg);
        write_reg(REG_CURRENT_LIMIT, 16'(cur));
        write_reg(REG_VOLT_HIGH, 16'(vhi));
        write_reg(REG_VOLT_LOW, 16'(vlo));
        write_reg(REG_DRIVER_TEMP, 16'(dtl));
        write_reg(REG_BOARD_TEMP, 16'(btl));
        write_reg(REG_CALIBRATED, 16'(cal));
        write_reg(REG_CHARGE_TICKS, 16'(chg));
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, each result transaction is
    // compared field by field against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.request_status = m_tdata[1:0];
            got.mode           = m_tdata[4:2];
            got.armed          = m_tdata[5];
            got.drive_on       = m_tdata[6];
            got.fault_flags    = m_tdata[11:7];
            got.report_pulse   = m_tdata[12];
            got.led_on         = m_tdata[13];
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing expected, tdata %h", $realtime, m_tdata);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.request_status !== want.request_status || got.mode !== want.mode ||
                    got.armed !== want.armed || got.drive_on !== want.drive_on ||
                    got.fault_flags !== want.fault_flags ||
                    got.report_pulse !== want.report_pulse || got.led_on !== want.led_on)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $write("%0t: mismatch exp/got status %0d/%0d mode %0d/%0d armed %b/%b ",
                               $realtime, want.request_status, got.request_status,
                               want.mode, got.mode, want.armed, got.armed);
                        $display("on %b/%b faults %b/%b report %b/%b led %b/%b",
                                 want.drive_on, got.drive_on,
                                 want.fault_flags, got.fault_flags,
                                 want.report_pulse, got.report_pulse,
                                 want.led_on, got.led_on);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed plan, then random phases under
    // several register settings and idle mixes
    // ------------------------------------------------------------------
    initial
    begin
        item_t it;
        int    phase_len [6];
        phase_len = '{100, 100, 30, 100, 100, 95};

        // Directed plan on reset limits with a one-tick charge delay
        plan = '{
            // boot: LED tick only advances the count
            '{ACT_LED, MODE_BOOT, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_BOOT},
            // boot: safety tick checks nothing, even at hot extremes
            '{ACT_SAFETY, MODE_BOOT, 16'sd0, 16'sd0, 16'd0, 12'sd2000, 12'sd2000,
              1'b1, STAT_OK, MODE_BOOT},
            '{ACT_REQUEST, MODE_RUN, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_INVALID, MODE_BOOT},
            '{ACT_REQUEST, MODE_IDLE, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_BOOT},
            '{ACT_CONTROL, MODE_BOOT, 16'sd0, 16'sd0, 16'd24000, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_IDLE},
            // idle again in idle: disarm, clear countdown
            '{ACT_REQUEST, MODE_IDLE, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_IDLE},
            '{ACT_REQUEST, MODE_BAD7, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_INVALID, MODE_IDLE},
            '{ACT_REQUEST, MODE_BAD5, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_INVALID, MODE_IDLE},
            '{ACT_REQUEST, MODE_BOOT, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_INVALID, MODE_IDLE},
            '{ACT_REQUEST, MODE_RUN, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_NOT_CAL, MODE_IDLE},
            '{ACT_REQUEST, MODE_ANTI, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_NOT_CAL, MODE_IDLE},
            // calibration needs no valid calibration
            '{ACT_REQUEST, MODE_CAL, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_IDLE},
            '{ACT_CONTROL, MODE_BOOT, 16'sd100, -16'sd200, 16'd24000, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_IDLE},
            '{ACT_CONTROL, MODE_BOOT, -16'sd300, 16'sd150, 16'd24000, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_CAL},
            '{ACT_CONTROL, MODE_BOOT, 16'sd8000, 16'sd8000, 16'd24000, 12'sd0, 12'sd0,
              1'b0, STAT_OK, MODE_CAL},
            // most negative samples: every phase trips over-current
            '{ACT_CONTROL, MODE_BOOT, 16'sh8000, 16'sh8000, 16'd24000, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_CAL},
            '{ACT_CONTROL, MODE_BOOT, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_IDLE},
            '{ACT_REQUEST, MODE_CAL, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_FAULTS, MODE_IDLE},
            '{ACT_SAFETY, MODE_BOOT, 16'sd0, 16'sd0, 16'd0, -12'sd1000, -12'sd1000,
              1'b1, STAT_OK, MODE_IDLE},
            '{ACT_SUPERVISE, MODE_BOOT, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_IDLE},
            '{ACT_CLEAR, MODE_BOOT, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_IDLE},
            '{ACT_CONTROL, MODE_BOOT, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b0, STAT_OK, MODE_IDLE},
            // under-voltage plus both temperatures hot
            '{ACT_SAFETY, MODE_BOOT, 16'sd0, 16'sd0, 16'd0, 12'sd2000, 12'sd2000,
              1'b0, STAT_OK, MODE_IDLE},
            // unused actions only report the state
            '{ACT_SPARE6, MODE_RUN, 16'sd0, 16'sd0, 16'd0, 12'sd0, 12'sd0,
              1'b1, STAT_OK, MODE_IDLE},
            '{ACT_SPARE7, MODE_BAD7, -16'sd1, -16'sd1, 16'hFFFF, -12'sd1, -12'sd1,
              1'b1, STAT_OK, MODE_IDLE}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(REG_CHARGE_TICKS, 16'd1);

        foreach (plan[i])
        begin
            it.action          = plan[i].act;
            it.requested_mode  = plan[i].req;
            it.phase_a_current = plan[i].ia;
            it.phase_b_current = plan[i].ib;
            it.bus_voltage     = plan[i].bus;
            it.driver_temp     = plan[i].dt;
            it.board_temp      = plan[i].bt;
            push_item(it, plan[i].pin, plan[i].pin_status, plan[i].pin_mode);
        end

        for (int p = 0; p < 6; p++)
        begin
            // sender holds off here until the block has drained
            settle_outputs();
            if (p < 2)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 65;
            end
            else if (p < 4)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: load_limits(20000, 50000, 12000, 1200, 1000, 1, 3);
                // lowest limits: any nonzero current trips, no calibration
                1: load_limits(0, 0, 0, -1000, -1000, 0, 0);
                // longest charge delay: idle is never left here
                2: load_limits(32767, 65535, 0, 2000, 2000, 1, 65535);
                3: load_limits($urandom_range(32767), $urandom_range(65535),
                               $urandom_range(65535), int'($urandom_range(3000)) - 1000,
                               int'($urandom_range(3000)) - 1000, 1, $urandom_range(4));
                4: load_limits(32767, 65535, 0, 2000, 2000, 1, 2);
                default: load_limits(1000 + $urandom_range(20000), 40000, 20000,
                                     800, 600, 1, 1);
            endcase
            for (int n = 0; n < phase_len[p]; n++)
                push_item(draw_item(), 1'b0, STAT_OK, MODE_BOOT);
        end

        settle_outputs();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/mdms_pkg.sv
rtl/core/mdms_cfg_regs.sv
rtl/core/mdms_step.sv
rtl/core/motor_drive_mode_supervisor_top.sv
verif/tb_motor_drive_mode_supervisor_top.sv
